@@ hdl/gfp_pkg.sv @@
// Shared types and constants for the guillotine first-fit packer.
// Used by gfp_ctrl, gfp_dpath and the top level; no dependencies.
package gfp_pkg;

    localparam int FREE_SLOTS = 32;
    localparam int DIM_W      = 20;
    localparam int SLOT_W     = (FREE_SLOTS > 1) ? $clog2(FREE_SLOTS) : 1;
    localparam int CNT_W      = $clog2(FREE_SLOTS + 1);
    localparam int ENTRY_W    = 4 * DIM_W;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CNT_W-1:0] SLOTS_CNT = CNT_W'(FREE_SLOTS);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DECK_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DECK_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_SPLIT   = 2'd2;

    localparam logic [DIM_W-1:0] MIN_SPLIT_RST = DIM_W'(10);

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_LOAD   = 8'b0000_0010,
        S_SCAN   = 8'b0000_0100,
        S_RDLAST = 8'b0000_1000,
        S_MOVE   = 8'b0001_0000,
        S_APPR   = 8'b0010_0000,
        S_APPT   = 8'b0100_0000,
        S_OUT    = 8'b1000_0000
    } t_state;

    typedef struct packed {
        logic accept;
        logic load;
        logic scan;
        logic rd_last;
        logic move;
        logic app_r;
        logic app_t;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic load_req;
        logic hit;
        logic miss;
        logic out_free;
    } t_status;

endpackage

@@ hdl/gfp_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module gfp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                                      i_clk,
    input  logic                                      i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                          i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/gfp_ctrl.sv @@
// Sequencer for the packer: accept, deck load, scan, remove, append, result.
// Depends on gfp_pkg; drives gfp_dpath through t_cmd, reads t_status.
module gfp_ctrl import gfp_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    input  t_status i_st,
    output t_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state = i_st.load_req ? S_LOAD : S_SCAN;
                end
            end
            S_LOAD: begin
                o_cmd.load = 1'b1;
                n_state = S_SCAN;
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_st.hit) begin
                    n_state = S_RDLAST;
                end else if (i_st.miss) begin
                    n_state = S_OUT;
                end
            end
            S_RDLAST: begin
                o_cmd.rd_last = 1'b1;
                n_state = S_MOVE;
            end
            S_MOVE: begin
                o_cmd.move = 1'b1;
                n_state = S_APPR;
            end
            S_APPR: begin
                o_cmd.app_r = 1'b1;
                n_state = S_APPT;
            end
            S_APPT: begin
                o_cmd.app_t = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (i_st.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

@@ hdl/gfp_dpath.sv @@
// Datapath: config registers, free-rectangle table, scan and split logic,
// output register. Depends on gfp_pkg and gfp_ram.
module gfp_dpath import gfp_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cmd                 i_cmd,
    output t_status              o_st,
    input  logic                 i_cfg_valid,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [DIM_W-1:0]     i_cfg_data,
    input  logic                 i_new_deck,
    input  logic [DIM_W-1:0]     i_item_length,
    input  logic [DIM_W-1:0]     i_item_width,
    input  logic                 i_out_stall,
    output logic                 o_out_valid,
    output logic                 o_placed,
    output logic [DIM_W-1:0]     o_pos_x,
    output logic [DIM_W-1:0]     o_pos_y
);

    logic [DIM_W-1:0]   r_deck_len;
    logic [DIM_W-1:0]   r_deck_wid;
    logic [DIM_W-1:0]   r_min_split;
    logic               r_deck_pending;
    logic [CNT_W-1:0]   r_total;
    logic [CNT_W-1:0]   r_idx;
    logic [SLOT_W-1:0]  r_chk_idx;
    logic               r_chk_vld;
    logic [SLOT_W-1:0]  r_hit_idx;
    logic [DIM_W-1:0]   r_len;
    logic [DIM_W-1:0]   r_wid;
    logic [DIM_W-1:0]   r_fx;
    logic [DIM_W-1:0]   r_fy;
    logic [DIM_W-1:0]   r_fw;
    logic [DIM_W-1:0]   r_fh;
    logic               r_placed;
    logic               r_out_vld;
    logic               r_out_placed;
    logic [DIM_W-1:0]   r_out_x;
    logic [DIM_W-1:0]   r_out_y;

    logic               ram_we;
    logic [SLOT_W-1:0]  ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic [SLOT_W-1:0]  ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;
    logic [DIM_W-1:0]   rd_w;
    logic [DIM_W-1:0]   rd_h;
    logic [CNT_W-1:0]   last_cnt;
    logic [DIM_W-1:0]   right_w;
    logic [DIM_W-1:0]   top_h;
    logic               room;
    logic               fit;

    // entry packing: {x, y, w, h}
    assign rd_w      = ram_rdata[2*DIM_W-1:DIM_W];
    assign rd_h      = ram_rdata[DIM_W-1:0];
    assign last_cnt  = r_total - 1'b1;
    assign right_w   = r_fw - r_len;
    assign top_h     = r_fh - r_wid;
    assign room      = (r_total < SLOTS_CNT);
    assign fit       = (r_len <= rd_w) && (r_wid <= rd_h);

    assign o_st.load_req = i_new_deck | r_deck_pending;
    assign o_st.hit      = r_chk_vld && fit;
    // nothing in flight and nothing left to issue
    assign o_st.miss     = !r_chk_vld && (r_idx >= r_total);
    assign o_st.out_free = !r_out_vld || !i_out_stall;

    assign ram_raddr = i_cmd.rd_last ? last_cnt[SLOT_W-1:0] : r_idx[SLOT_W-1:0];

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_total[SLOT_W-1:0];
        ram_wdata = {r_fx, r_fy, r_fw, r_fh};
        if (i_cmd.load) begin
            ram_we    = 1'b1;
            ram_waddr = '0;
            ram_wdata = {{DIM_W{1'b0}}, {DIM_W{1'b0}}, r_deck_len, r_deck_wid};
        end else if (i_cmd.move) begin
            ram_we    = 1'b1;
            ram_waddr = r_hit_idx;
            ram_wdata = ram_rdata;
        end else if (i_cmd.app_r) begin
            ram_we    = (right_w > r_min_split) && room;
            ram_wdata = {r_fx + r_len, r_fy, right_w, r_fh};
        end else if (i_cmd.app_t) begin
            ram_we    = (top_h > r_min_split) && room;
            ram_wdata = {r_fx, r_fy + r_wid, r_len, top_h};
        end
    end

    gfp_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (FREE_SLOTS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deck_len     <= '0;
            r_deck_wid     <= '0;
            r_min_split    <= MIN_SPLIT_RST;
            r_deck_pending <= 1'b1;
            r_total        <= '0;
            r_idx          <= '0;
            r_chk_vld      <= 1'b0;
            r_out_vld      <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_DECK_LENGTH: r_deck_len  <= i_cfg_data;
                    CFG_DECK_WIDTH:  r_deck_wid  <= i_cfg_data;
                    CFG_MIN_SPLIT:   r_min_split <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (i_cmd.accept) begin
                r_idx     <= '0;
                r_chk_vld <= 1'b0;
            end
            if (i_cmd.load) begin
                r_total        <= CNT_W'(1);
                r_deck_pending <= 1'b0;
            end
            if (i_cmd.scan) begin
                r_chk_vld <= (r_idx < r_total);
                if (r_idx < r_total) begin
                    r_idx <= r_idx + 1'b1;
                end
            end
            if (i_cmd.move) begin
                r_total <= last_cnt;
            end
            if ((i_cmd.app_r || i_cmd.app_t) && ram_we) begin
                r_total <= r_total + 1'b1;
            end
            if (i_cmd.out_load) begin
                r_out_vld <= 1'b1;
            end else if (r_out_vld && !i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_len    <= i_item_length;
            r_wid    <= i_item_width;
            r_placed <= 1'b0;
        end
        if (i_cmd.scan) begin
            r_chk_idx <= r_idx[SLOT_W-1:0];
        end
        if (i_cmd.scan && o_st.hit) begin
            r_hit_idx <= r_chk_idx;
            r_placed  <= 1'b1;
            r_fx      <= ram_rdata[4*DIM_W-1:3*DIM_W];
            r_fy      <= ram_rdata[3*DIM_W-1:2*DIM_W];
            r_fw      <= rd_w;
            r_fh      <= rd_h;
        end
        if (i_cmd.out_load) begin
            r_out_placed <= r_placed;
            r_out_x      <= r_placed ? r_fx : '0;
            r_out_y      <= r_placed ? r_fy : '0;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_placed    = r_out_placed;
    assign o_pos_x     = r_out_x;
    assign o_pos_y     = r_out_y;

    a_total_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_total <= SLOTS_CNT)
        else $error("free count above table size");

    a_hit_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cmd.scan && o_st.hit && o_st.miss))
        else $error("scan reports hit and miss together");

    a_load_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load |=> (r_total == CNT_W'(1)))
        else $error("deck load did not leave one free entry");

    a_out_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> o_st.out_free)
        else $error("result register overwritten while held");

    a_move_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.rd_last |-> (r_total != '0))
        else $error("entry removal from empty table");

endmodule

@@ hdl/guillotine_first_fit_packer_unit.sv @@
// Guillotine first-fit packer, top level. Each accepted item is scanned first-fit over the
// free table, after a deck load step when a new deck is requested or none has been loaded
// since reset: the scan reads one table entry per cycle through the single read port of
// the 32-entry free table, and on a hit the removal of that entry and the two appends of
// the split follow before the result. A new item is taken in the cycle after the previous
// result is loaded into the output register. Config writes are always ready and land at once.
// Depends on gfp_pkg, gfp_ctrl, gfp_dpath and gfp_ram.
module guillotine_first_fit_packer_unit import gfp_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [DIM_W-1:0]     i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic                 i_new_deck,
    input  logic [DIM_W-1:0]     i_item_length,
    input  logic [DIM_W-1:0]     i_item_width,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic                 o_placed,
    output logic [DIM_W-1:0]     o_pos_x,
    output logic [DIM_W-1:0]     o_pos_y
);

    t_cmd    cmd;
    t_status st;

    assign o_cfg_ready = 1'b1;

    gfp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_st       (st),
        .o_cmd      (cmd)
    );

    gfp_dpath u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_st          (st),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_new_deck    (i_new_deck),
        .i_item_length (i_item_length),
        .i_item_width  (i_item_width),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_placed      (o_placed),
        .o_pos_x       (o_pos_x),
        .o_pos_y       (o_pos_y)
    );

endmodule
